[sv/twa_pkg.sv]
// twa_pkg: shared widths and defaults for the trimmed window average block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package twa_pkg;

  // Width of one sample and of one averaged result
  localparam int SAMPLE_W = 16;

  // Default window length (legal range 3..64)
  localparam int WINDOW_DEF = 25;

endpackage : twa_pkg

[sv/twa_cell.sv]
// twa_cell: one storage cell of the sample chain, loads from its neighbor.
// Depends on twa_pkg.
`timescale 1ns / 1ps

module twa_cell
  import twa_pkg::*;
#(
  parameter int WIDTH = SAMPLE_W
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [WIDTH-1:0] d_in,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] val_r;
  logic [WIDTH-1:0] val_nxt;

  assign val_nxt = shift_en ? d_in : val_r;

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule : twa_cell

[sv/twa_div.sv]
// twa_div: divide by one of two constant divisors by reciprocal multiply.
// Quotient must fit in Q_W bits. Depends on twa_pkg.
`timescale 1ns / 1ps

module twa_div
  import twa_pkg::*;
#(
  parameter int NUM_W    = 21,
  parameter int Q_W      = SAMPLE_W,
  parameter int TRIM_DIV = WINDOW_DEF - 2,
  parameter int FULL_DIV = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             trim,
  input  logic [NUM_W-1:0] dividend,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  // K >= NUM_W + log2(divisor) keeps floor(x * M / 2^K) exact for every
  // dividend, with M = ceil(2^K / divisor); FULL_DIV is the larger divisor
  localparam int K   = NUM_W + $clog2(FULL_DIV);
  localparam int M_W = K + 1;
  localparam int P_W = K + Q_W;
  localparam logic [63:0]    POW_K      = 64'd1 << K;
  localparam logic [M_W-1:0] RECIP_TRIM =
    M_W'((POW_K + 64'(TRIM_DIV - 1)) / 64'(TRIM_DIV));
  localparam logic [M_W-1:0] RECIP_FULL =
    M_W'((POW_K + 64'(FULL_DIV - 1)) / 64'(FULL_DIV));

  logic [NUM_W-1:0] num_r;
  logic             trim_r;
  logic             go_r;
  logic             done_r;
  logic [Q_W-1:0]   q_r;
  logic [M_W-1:0]   recip;
  logic [P_W-1:0]   prod;

  // quotient below 2^Q_W keeps the product below 2^P_W
  assign recip = trim_r ? RECIP_TRIM : RECIP_FULL;
  assign prod  = P_W'(num_r) * P_W'(recip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      go_r   <= start;
      done_r <= go_r;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= dividend;
      trim_r <= trim;
    end
    if (go_r) begin
      q_r <= prod[K +: Q_W];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule : twa_div

[sv/trimmed_window_average.sv]
// trimmed_window_average: top level, moving average with min/max trimming.
// Depends on twa_pkg, twa_cell, twa_div.
`timescale 1ns / 1ps
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_stall, in_sample[15:0]    | in
//  result  | out_valid, out_stall, out_average[15:0], | out
//          | out_window_full                        |
//
//  Sequence: a fill item is echoed in the cycle after acceptance. A full-window
//  item reaches a valid result through one walk step per cell, a shift-in step
//  that starts the divider, a multiply step, a capture step and the output
//  load. in_stall stays high meanwhile.
//  Reset clears fill count, control and output valid; cell contents are
//  undefined until written. A stalled result holds in_stall high until it leaves.

module trimmed_window_average
  import twa_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_average,
  output logic                out_window_full
);

  localparam int CNT_W = $clog2(WINDOW + 1);    // fill count 0..WINDOW
  localparam int IDX_W = $clog2(WINDOW);        // walk index 0..WINDOW-1
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    fill_r;
  logic [IDX_W-1:0]    idx_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] lo_r, hi_r;
  logic [SAMPLE_W-1:0] samp_r;
  logic [SAMPLE_W-1:0] res_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic                out_full_r;

  logic                in_acc;
  logic                out_free;
  logic                win_full;
  logic                load_out;

  // chain of cells: entry 0 is the oldest sample, WINDOW-1 the newest
  logic [SAMPLE_W-1:0] cell_q [WINDOW];
  logic [SAMPLE_W-1:0] tail_in;
  logic                shift_en;

  logic [SAMPLE_W-1:0] head;
  logic                trim;
  logic [SUM_W-1:0]    dividend;
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_q;

  assign win_full = (fill_r == CNT_W'(WINDOW));
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign head     = cell_q[0];

  // output register loads on a fill echo or when the average is ready
  assign load_out = ((state_r == S_IDLE) && in_acc && !win_full) ||
                    ((state_r == S_OUT) && out_free);

  // fill items shift straight in; walk recirculates the head; the load
  // cycle drops the oldest entry and shifts in the held sample
  always_comb begin
    shift_en = 1'b0;
    tail_in  = head;
    unique case (state_r)
      S_IDLE: begin
        shift_en = in_acc && !win_full;
        tail_in  = in_sample;
      end
      S_WALK: begin
        shift_en = 1'b1;
        tail_in  = head;
      end
      S_LOAD: begin
        shift_en = 1'b1;
        tail_in  = samp_r;
      end
      S_DIV, S_OUT: begin
        shift_en = 1'b0;
        tail_in  = head;
      end
      default: begin
        shift_en = 1'b0;
        tail_in  = head;
      end
    endcase
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_W-1:0] d;
    if (i == WINDOW - 1) begin : g_tail
      assign d = tail_in;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    twa_cell #(
      .WIDTH (SAMPLE_W)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (d),
      .q        (cell_q[i])
    );
  end

  // trim one min and one max unless all entries are equal
  assign trim      = (lo_r < hi_r);
  assign dividend  = trim ? (sum_r - SUM_W'(lo_r) - SUM_W'(hi_r)) : sum_r;
  assign div_start = (state_r == S_LOAD);

  // divides by WINDOW-2 when trimming, else by WINDOW
  twa_div #(
    .NUM_W    (SUM_W),
    .Q_W      (SAMPLE_W),
    .TRIM_DIV (WINDOW - 2),
    .FULL_DIV (WINDOW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .trim     (trim),
    .dividend (dividend),
    .done     (div_done),
    .quotient (div_q)
  );

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (win_full) begin
              state_r <= S_WALK;
              idx_r   <= '0;
            end else begin
              // window still filling: pass the sample through
              fill_r     <= fill_r + 1'b1;
              out_avg_r  <= in_sample;
              out_full_r <= 1'b0;
            end
          end
        end
        S_WALK: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == IDX_W'(WINDOW - 1)) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= div_q;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_avg_r  <= res_r;
            out_full_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // walk accumulators and held sample
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r <= in_sample;
    end
    if (state_r == S_WALK) begin
      if (idx_r == '0) begin
        sum_r <= SUM_W'(head);
        lo_r  <= head;
        hi_r  <= head;
      end else begin
        sum_r <= sum_r + SUM_W'(head);
        if (head < lo_r) lo_r <= head;
        if (head > hi_r) hi_r <= head;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_avg_r;
  assign out_window_full = out_full_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // fill count never passes the window length
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("fill count above window length");

  // a walk only ever runs over a full window
  a_walk_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> win_full)
    else $error("walk started on a partial window");

  // an item taken on a full window starts the walk, not a pass-through
  a_full_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && win_full) |=> (state_r == S_WALK) && !$rose(out_valid_r))
    else $error("full-window item did not start walk");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");

endmodule : trimmed_window_average
